>>> rtl/core/fsm_pkg.sv
// Package for the first substring match block: sizes, command codes and the
// per-cell control struct. Used by fsm_cell and first_substring_match.
`default_nettype none

package fsm_pkg;

    // Number of pattern bytes the block can hold, one chain cell per byte.
    localparam int PATTERN_MAX = 32;
    // Width of a pattern index and of the rotation slot counter.
    localparam int IDX_W = $clog2(PATTERN_MAX);
    // Width of the pattern length register (must hold PATTERN_MAX itself).
    localparam int LEN_W = 6;
    // Width of the text position counter.
    localparam int POS_W = 32;
    localparam logic [POS_W-1:0] POS_MAX = '1;
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(PATTERN_MAX);

    // Request command codes.
    localparam logic [1:0] CMD_LOAD = 2'd0;
    localparam logic [1:0] CMD_TEXT = 2'd1;
    localparam logic [1:0] CMD_END  = 2'd2;

    // Control shared by every cell in the chain.
    typedef struct packed {
        logic shift;   // a text byte moves one cell down the window
        logic rotate;  // pattern bytes move one cell round the ring
    } t_cell_ctl;

endpackage

`default_nettype wire

>>> rtl/core/fsm_cell.sv
// One cell of the match chain: one text window byte and one pattern byte.
// Depends on fsm_pkg for the control struct.
`default_nettype none

module fsm_cell (
    input  wire logic               i_clk,
    input  wire fsm_pkg::t_cell_ctl i_ctl,
    input  wire logic               i_load,
    input  wire logic [7:0]         i_load_byte,
    input  wire logic [7:0]         i_text_in,
    input  wire logic [7:0]         i_pat_in,
    output logic      [7:0]         o_text,
    output logic      [7:0]         o_pat,
    output logic                    o_eq
);

    logic [7:0] r_text;
    logic [7:0] r_pat;

    // Window byte: takes the neighbor's byte whenever a text byte arrives.
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_text <= i_text_in;
        end
    end

    // Pattern byte: written by a load, or passed along the ring on realignment.
    always_ff @(posedge i_clk) begin
        if (i_ctl.rotate) begin
            r_pat <= i_pat_in;
        end else if (i_load) begin
            r_pat <= i_load_byte;
        end
    end

    // Compare the byte this cell is about to hold against its pattern byte.
    assign o_eq   = (i_text_in == r_pat);
    assign o_text = r_text;
    assign o_pat  = r_pat;

endmodule

`default_nettype wire

>>> rtl/core/first_substring_match.sv
// Top level of the first substring match block: a chain of fsm_cell instances,
// the text position counter, the pattern alignment ring control and the result register.
// Depends on fsm_pkg and fsm_cell.
`default_nettype none

// The block takes one request per clock cycle while it does not stall: pattern
// loads, text bytes and end-of-text requests each finish in the cycle they are
// accepted, and the result of an end-of-text request appears in the output
// register on the next cycle. Pattern bytes sit in a ring of cells ordered so
// that each cell lines up with a fixed window position for the current pattern
// length. After a write of pattern_length the ring turns one cell per cycle
// until it lines up again, and input requests stall while it turns. Input also
// stalls while a finished result waits and the output side stalls. Lengths
// above PATTERN_MAX act as PATTERN_MAX; an empty pattern reports found at
// position 0, and the position counter saturates.
module first_substring_match (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // Input request channel.
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [1:0]                    i_command,
    input  wire logic [fsm_pkg::IDX_W-1:0]     i_pattern_index,
    input  wire logic [7:0]                    i_byte_value,
    // Result channel.
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic                               o_found,
    output logic      [fsm_pkg::POS_W-1:0]     o_match_position,
    // Configuration write channel (pattern_length).
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [fsm_pkg::LEN_W-1:0]     i_cfg_data
);

    localparam int PM = fsm_pkg::PATTERN_MAX;

    logic [fsm_pkg::LEN_W-1:0] r_length;
    logic [fsm_pkg::IDX_W-1:0] r_align;
    logic [fsm_pkg::POS_W-1:0] r_bytes_seen;
    logic [fsm_pkg::POS_W-1:0] n_bytes_seen;
    logic                      r_match_seen;
    logic [fsm_pkg::POS_W-1:0] r_first_start;
    logic                      r_out_valid;
    logic                      r_found;
    logic [fsm_pkg::POS_W-1:0] r_match_position;

    logic [fsm_pkg::LEN_W-1:0] leff;
    logic [fsm_pkg::IDX_W-1:0] align_target;
    logic                      realign;
    logic                      out_free;
    logic                      accept;
    logic                      is_load;
    logic                      is_text;
    logic                      is_end;
    logic [fsm_pkg::IDX_W-1:0] wr_slot;
    logic [PM-1:0]             load_en;
    logic [PM-1:0]             mask;
    logic [PM-1:0]             eq;
    logic                      hit;
    fsm_pkg::t_cell_ctl        ctl;
    logic [7:0]                w_text [PM];
    logic [7:0]                w_pat  [PM];

    // Effective length and the ring alignment it needs (full length wraps to 0).
    assign leff         = (r_length > fsm_pkg::LEN_MAX) ? fsm_pkg::LEN_MAX : r_length;
    assign align_target = leff[fsm_pkg::IDX_W-1:0];
    assign realign      = (r_align != align_target);

    // Handshakes.
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = realign || !out_free;
    assign accept      = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    assign is_load = accept && (i_command == fsm_pkg::CMD_LOAD);
    assign is_text = accept && (i_command == fsm_pkg::CMD_TEXT);
    assign is_end  = accept && (i_command == fsm_pkg::CMD_END);

    // Cell control (shift, then rotate) and the one-hot write slot of a pattern load.
    assign ctl     = {is_text, realign};
    assign wr_slot = r_align - fsm_pkg::IDX_W'(1) - i_pattern_index;

    always_comb begin
        for (int k = 0; k < PM; k++) begin
            load_en[k] = is_load && (wr_slot == fsm_pkg::IDX_W'(k));
            mask[k]    = (fsm_pkg::LEN_W'(k) < leff);
        end
    end

    // The chain of cells: text moves toward higher cells, pattern turns round a ring.
    for (genvar k = 0; k < PM; k++) begin : g_cell
        fsm_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (ctl),
            .i_load      (load_en[k]),
            .i_load_byte (i_byte_value),
            .i_text_in   ((k == 0) ? i_byte_value : w_text[(k + PM - 1) % PM]),
            .i_pat_in    (w_pat[(k + PM - 1) % PM]),
            .o_text      (w_text[k]),
            .o_pat       (w_pat[k]),
            .o_eq        (eq[k])
        );
    end

    // Saturating text position and the first-match test on the shifted window.
    assign n_bytes_seen = (r_bytes_seen == fsm_pkg::POS_MAX) ? r_bytes_seen
                                                             : r_bytes_seen + 1'b1;
    assign hit = is_text && !r_match_seen && (leff != '0)
              && (n_bytes_seen >= fsm_pkg::POS_W'(leff)) && (&(eq | ~mask));

    // Configuration register and ring alignment.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_length <= '0;
            r_align  <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_length <= i_cfg_data;
            end
            if (realign) begin
                r_align <= r_align + 1'b1;
            end
        end
    end

    // Text state: cleared by an end-of-text request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_seen  <= '0;
            r_match_seen  <= 1'b0;
            r_first_start <= '0;
        end else if (is_end) begin
            r_bytes_seen  <= '0;
            r_match_seen  <= 1'b0;
            r_first_start <= '0;
        end else if (is_text) begin
            r_bytes_seen <= n_bytes_seen;
            if (hit) begin
                r_match_seen  <= 1'b1;
                r_first_start <= n_bytes_seen - fsm_pkg::POS_W'(leff);
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= is_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && is_end) begin
            r_found          <= (leff == '0) || r_match_seen;
            r_match_position <= ((leff != '0) && r_match_seen) ? r_first_start : '0;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_found          = r_found;
    assign o_match_position = r_match_position;

    // An accepted end-of-text request shows its result on the next cycle.
    a_end_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && (i_command == fsm_pkg::CMD_END)) |=> o_out_valid)
        else $error("end-of-text request gave no result");

    // A not-found result always reports position zero.
    a_not_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_found) |-> (o_match_position == '0))
        else $error("not-found result with nonzero position");

    // A recorded match never starts beyond the bytes seen so far.
    a_start_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_match_seen |-> (r_first_start <= r_bytes_seen))
        else $error("match start beyond text position");

    // No pattern load lands while the ring is turning.
    a_no_load_realign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_align != align_target) |-> (load_en == '0))
        else $error("pattern load during realignment");

endmodule

`default_nettype wire

>>> test/first_substring_match_checker.sv
// Checker for the first substring match block: watches the request, result and
// configuration channels, predicts every result and compares it field by field.
// Depends on fsm_pkg for sizes and command codes.

module first_substring_match_checker
    import fsm_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic              i_in_stall,
    input  wire logic [1:0]        i_command,
    input  wire logic [IDX_W-1:0]  i_pattern_index,
    input  wire logic [7:0]        i_byte_value,
    input  wire logic              i_out_valid,
    input  wire logic              i_out_stall,
    input  wire logic              i_found,
    input  wire logic [POS_W-1:0]  i_match_position,
    input  wire logic              i_cfg_valid,
    input  wire logic              i_cfg_ready,
    input  wire logic [LEN_W-1:0]  i_cfg_data,
    output int                     o_pending,
    output int                     o_failures
);

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
    } t_search_result;

    // Predicted state of the block.
    logic [7:0]       pattern_mem [PATTERN_MAX];
    logic [7:0]       recent_bytes [PATTERN_MAX];
    logic [POS_W-1:0] byte_count = '0;
    logic             match_hit = 1'b0;
    logic [POS_W-1:0] match_start = '0;
    logic [LEN_W-1:0] length_reg = '0;

    // Results predicted for accepted end-of-text requests, oldest first.
    t_search_result   search_results [$];
    int               mismatch_count = 0;

    // Lengths above the store size behave as the full store.
    function automatic int used_length();
        return (length_reg > LEN_MAX) ? PATTERN_MAX : int'(length_reg);
    endfunction

    task automatic clear_text_state();
        for (int k = 0; k < PATTERN_MAX; k++) begin
            recent_bytes[k] = 8'h00;
        end
        byte_count  = '0;
        match_hit   = 1'b0;
        match_start = '0;
    endtask

    // Shift one text byte into the window and look for the first full match.
    task automatic take_text_byte(input logic [7:0] text_byte);
        int len;
        bit same;
        len = used_length();
        for (int k = PATTERN_MAX - 1; k > 0; k--) begin
            recent_bytes[k] = recent_bytes[k - 1];
        end
        recent_bytes[0] = text_byte;
        if (byte_count != POS_MAX) begin
            byte_count++;
        end
        if (!match_hit && len > 0 && byte_count >= POS_W'(len)) begin
            same = 1'b1;
            // Pattern byte j lines up with the byte len-1-j places back.
            for (int j = 0; j < len; j++) begin
                if (recent_bytes[len - 1 - j] !== pattern_mem[j]) begin
                    same = 1'b0;
                end
            end
            if (same) begin
                match_hit   = 1'b1;
                match_start = byte_count - POS_W'(len);
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_search_result want;
        if (!i_rst_n) begin
            clear_text_state();
            length_reg = '0;
            search_results.delete();
            mismatch_count = 0;
        end else begin
            // A result taken at this edge belongs to the oldest end-of-text request.
            if (i_out_valid && !i_out_stall) begin
                if (search_results.size() == 0) begin
                    $error("result with no request waiting: found %0d, match_position %0d",
                           i_found, i_match_position);
                    mismatch_count++;
                end else begin
                    want = search_results.pop_front();
                    if (i_found !== want.found) begin
                        $error("found mismatch: expected %0d, got %0d", want.found, i_found);
                        mismatch_count++;
                    end
                    if (i_match_position !== want.position) begin
                        $error("match_position mismatch: expected %0d, got %0d",
                               want.position, i_match_position);
                        mismatch_count++;
                    end
                end
            end

            // Accepted request; it still sees the length from before this edge.
            if (i_in_valid && !i_in_stall) begin
                case (i_command)
                    CMD_LOAD: begin
                        if (i_pattern_index < PATTERN_MAX) begin
                            pattern_mem[i_pattern_index] = i_byte_value;
                        end
                    end
                    CMD_TEXT: begin
                        take_text_byte(i_byte_value);
                    end
                    CMD_END: begin
                        if (used_length() == 0) begin
                            want = '{found: 1'b1, position: '0};
                        end else if (match_hit) begin
                            want = '{found: 1'b1, position: match_start};
                        end else begin
                            want = '{found: 1'b0, position: '0};
                        end
                        search_results.push_back(want);
                        clear_text_state();
                    end
                    default: begin
                    end
                endcase
            end

            // Pattern length register write.
            if (i_cfg_valid && i_cfg_ready) begin
                length_reg = i_cfg_data;
            end
        end
        o_pending  <= search_results.size();
        o_failures <= mismatch_count;
    end

endmodule

>>> test/first_substring_match_tb.sv
// Testbench top for the first substring match block: clock, reset, request and
// configuration stimulus, receiver stalls and the final verdict.
// Depends on fsm_pkg, first_substring_match and first_substring_match_checker.

module first_substring_match_tb;
    import fsm_pkg::*;

    // Command code that the block ignores.
    localparam logic [1:0] CMD_SPARE     = 2'd3;
    localparam int         ITEM_TARGET   = 1350;
    localparam int         CYCLE_LIMIT   = 400000;
    localparam int         SETTLE_CYCLES = 4;

    typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_TOGGLE} t_rx_mode;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic [1:0]       command = CMD_LOAD;
    logic [IDX_W-1:0] pattern_index = '0;
    logic [7:0]       byte_value = 8'h00;
    logic             out_stall = 1'b0;
    logic             cfg_valid = 1'b0;
    logic [LEN_W-1:0] cfg_data = '0;

    logic             in_stall;
    logic             out_valid;
    logic             found;
    logic [POS_W-1:0] match_position;
    logic             cfg_ready;

    int               pending;
    int               failures;

    // Stimulus bookkeeping: a copy of the loaded pattern and which entries hold data.
    logic [7:0]       pattern_copy [PATTERN_MAX];
    bit               entry_loaded [PATTERN_MAX];
    int               len_now = 0;
    int               burst_left = 0;
    int               items_sent = 0;
    logic [7:0]       sym_a = 8'hAB;
    logic [7:0]       sym_b = 8'hCD;

    t_rx_mode         rx_mode = RX_OPEN;
    int               rx_left = 0;
    int               hold_left = 0;
    int               rx_cycles = 0;
    int               cycle_count = 0;

    first_substring_match u_dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_command        (command),
        .i_pattern_index  (pattern_index),
        .i_byte_value     (byte_value),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_found          (found),
        .o_match_position (match_position),
        .i_cfg_valid      (cfg_valid),
        .o_cfg_ready      (cfg_ready),
        .i_cfg_data       (cfg_data)
    );

    first_substring_match_checker u_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_stall       (in_stall),
        .i_command        (command),
        .i_pattern_index  (pattern_index),
        .i_byte_value     (byte_value),
        .i_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .i_found          (found),
        .i_match_position (match_position),
        .i_cfg_valid      (cfg_valid),
        .i_cfg_ready      (cfg_ready),
        .i_cfg_data       (cfg_data),
        .o_pending        (pending),
        .o_failures       (failures)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Run limit.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Receiver: randomly chosen stall patterns, each held for a random stretch, plus a long
    // hold-off now and then so that results back up and the input stalls.
    always @(posedge clk) begin
        rx_cycles++;
        if (rx_cycles % 2500 == 1200) begin
            hold_left = 300;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else begin
            if (rx_left == 0) begin
                rx_mode = t_rx_mode'($urandom_range(0, 3));
                rx_left = $urandom_range(16, 96);
            end else begin
                rx_left--;
            end
            case (rx_mode)
                RX_OPEN:  out_stall <= 1'b0;
                RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
                RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
                default:  out_stall <= ~out_stall;
            endcase
        end
    end

    // Mostly the two symbols of the current phase, so that matches are common.
    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            return 8'($urandom_range(0, 255));
        end
        return (r < 5) ? sym_a : sym_b;
    endfunction

    // Offer one request and hold it until taken; then keep or break the burst.
    task automatic send(input logic [1:0] cmd, input int idx, input int value);
        in_valid      <= 1'b1;
        command       <= cmd;
        pattern_index <= IDX_W'(idx);
        byte_value    <= 8'(value);
        do @(posedge clk); while (in_stall);
        if (cmd == CMD_LOAD) begin
            pattern_copy[idx] = 8'(value);
            entry_loaded[idx] = 1'b1;
        end
        if (cmd != CMD_SPARE) begin
            items_sent++;
        end
        if (burst_left == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
        end else begin
            burst_left--;
        end
    endtask

    // Stop offering and wait until every predicted result has been taken.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Load any pattern entry the new length would compare, then write the length.
    task automatic set_length(input int value);
        int eff;
        eff = (value > PATTERN_MAX) ? PATTERN_MAX : value;
        for (int i = 0; i < eff; i++) begin
            if (!entry_loaded[i]) begin
                send(CMD_LOAD, i, pick_byte());
            end
        end
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= LEN_W'(value);
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        len_now = eff;
    endtask

    initial begin
        int phase_no;
        int new_len;
        int eff;
        int text_len;
        int roll;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty pattern: found at position 0, with and without text.
        send(CMD_END, 0, 8'h00);
        send(CMD_TEXT, 0, 8'h00);
        send(CMD_TEXT, 31, 8'hFF);
        send(CMD_END, 31, 8'hFF);

        // Two-byte pattern; a text shorter than the pattern finds nothing.
        send(CMD_LOAD, 0, 8'hAB);
        send(CMD_LOAD, 1, 8'hCD);
        send(CMD_LOAD, 31, 8'h00);
        set_length(2);
        send(CMD_TEXT, 0, 8'hAB);
        send(CMD_END, 0, 8'h00);

        // First of two occurrences wins.
        send(CMD_TEXT, 0, 8'h00);
        send(CMD_TEXT, 0, 8'hAB);
        send(CMD_TEXT, 0, 8'hCD);
        send(CMD_TEXT, 0, 8'hAB);
        send(CMD_TEXT, 0, 8'hCD);
        send(CMD_END, 0, 8'h00);

        // The unused command is ignored.
        send(CMD_SPARE, 5, 8'h5A);

        // A pattern load in the middle of a text applies to the next compare.
        send(CMD_TEXT, 0, 8'hAB);
        send(CMD_LOAD, 1, 8'hEE);
        send(CMD_TEXT, 0, 8'hEE);
        send(CMD_END, 0, 8'h00);

        // A length change in the middle of a text.
        send(CMD_TEXT, 0, 8'h11);
        send(CMD_TEXT, 0, 8'h22);
        send(CMD_TEXT, 0, 8'h33);
        set_length(1);
        send(CMD_TEXT, 0, 8'hAB);
        send(CMD_END, 0, 8'h00);

        // Random phases: a length, fresh pattern bytes, then several texts.
        items_sent = 0;
        phase_no = 0;
        while (items_sent < ITEM_TARGET) begin
            case (phase_no)
                0: new_len = PATTERN_MAX;
                1: new_len = 63;
                2: new_len = 0;
                default: begin
                    roll = $urandom_range(0, 19);
                    if (roll == 0) begin
                        new_len = 0;
                    end else if (roll < 3) begin
                        new_len = $urandom_range(33, 63);
                    end else if (roll < 6) begin
                        new_len = $urandom_range(5, 32);
                    end else begin
                        new_len = $urandom_range(1, 4);
                    end
                end
            endcase
            sym_a = 8'($urandom_range(0, 255));
            sym_b = 8'($urandom_range(0, 255));
            eff = (new_len > PATTERN_MAX) ? PATTERN_MAX : new_len;
            for (int i = 0; i < eff; i++) begin
                if ($urandom_range(0, 1) == 1) begin
                    send(CMD_LOAD, i, pick_byte());
                end
            end
            set_length(new_len);

            repeat ($urandom_range(1, 4)) begin
                text_len = $urandom_range(0, len_now + 12);
                for (int j = 0; j < text_len; j++) begin
                    roll = $urandom_range(0, 99);
                    if (roll < 3) begin
                        send(CMD_LOAD, $urandom_range(0, PATTERN_MAX - 1),
                             $urandom_range(0, 255));
                    end else if (roll < 5) begin
                        send(CMD_SPARE, $urandom_range(0, 31), $urandom_range(0, 255));
                    end else if (roll < 9) begin
                        // Plant a full copy of the pattern.
                        for (int k = 0; k < len_now; k++) begin
                            send(CMD_TEXT, $urandom_range(0, 31), pattern_copy[k]);
                        end
                    end else if (roll == 9) begin
                        set_length($urandom_range(0, 63));
                    end else begin
                        send(CMD_TEXT, $urandom_range(0, 31), pick_byte());
                    end
                end
                send(CMD_END, $urandom_range(0, 31), $urandom_range(0, 255));
            end
            phase_no++;
        end

        settle();
        repeat (8) @(posedge clk);
        if (failures == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/fsm_pkg.sv
rtl/core/fsm_cell.sv
rtl/core/first_substring_match.sv
test/first_substring_match_checker.sv
test/first_substring_match_tb.sv
